>>> rtl/core/assert_macros.svh
// assertion macros for the rtl file that carries checks
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/core/fbpa_pkg.sv
// types, constants and state codes of the fixed block pool allocator
// no dependencies
package fbpa_pkg;

    localparam int MAX_CHUNKS = 256;
    localparam int IDX_W      = $clog2(MAX_CHUNKS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int BIT_W      = $clog2(IDX_W);
    localparam int ADDR_W     = 32;
    localparam int SIZE_W     = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_W      = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHUNK_SIZE   = 2'd0,
        CFG_CHUNK_COUNT  = 2'd1,
        CFG_BASE_ADDRESS = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACHK,
        S_BUILD,
        S_ARD,
        S_MUL,
        S_ABASE,
        S_FOFF,
        S_FRNG,
        S_FDIV,
        S_FCHK,
        S_OUT
    } t_state;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [IDX_W-1:0] wdata;
        logic [IDX_W-1:0] raddr;
    } t_stack_req;

    typedef struct packed {
        logic              sub;
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] b;
    } t_alu_req;

endpackage

>>> rtl/core/fbpa_alu.sv
// shared add/subtract unit used for offset, range check, division steps, multiply steps and base add
// depends on fbpa_pkg
module fbpa_alu (
    input  fbpa_pkg::t_alu_req           i_req,
    output logic [fbpa_pkg::ADDR_W-1:0]  o_sum,
    output logic                         o_carry
);

    logic [fbpa_pkg::ADDR_W-1:0] w_b;

    assign w_b = i_req.sub ? ~i_req.b : i_req.b;

    // carry out on subtract means a >= b
    assign {o_carry, o_sum} = {1'b0, i_req.a} + {1'b0, w_b}
                            + (fbpa_pkg::ADDR_W + 1)'(i_req.sub);

endmodule

>>> rtl/core/fbpa_stack.sv
// free index stack memory, one write and one registered read port
// depends on fbpa_pkg
module fbpa_stack (
    input  logic                         i_clk,
    input  fbpa_pkg::t_stack_req         i_req,
    output logic [fbpa_pkg::IDX_W-1:0]   o_rdata
);

    logic [fbpa_pkg::IDX_W-1:0] r_mem [fbpa_pkg::MAX_CHUNKS];
    logic [fbpa_pkg::IDX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/fixed_block_pool_allocator.sv
// fixed block pool allocator, one item at a time: a served allocate or a free inside the region
// runs 8 shared adder steps before its result, while a refused allocate and a free beyond the
// region skip them; the next item is taken once the result loads into the output register,
// later while a result waits for ready; the first enabled allocate first builds the free stack
// synchronous active-low reset clears control, marks and config, no clear pass
// depends on fbpa_pkg, fbpa_alu, fbpa_stack and assert_macros.svh
module fixed_block_pool_allocator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fbpa_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_op,
    input  logic [31:0]                       i_request_size,
    input  logic [31:0]                       i_free_address,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [31:0]                       o_address,
    output logic                              o_in_pool
);

    localparam int IDX_W  = fbpa_pkg::IDX_W;
    localparam int CNT_W  = fbpa_pkg::CNT_W;
    localparam int BIT_W  = fbpa_pkg::BIT_W;
    localparam int ADDR_W = fbpa_pkg::ADDR_W;
    localparam int SIZE_W = fbpa_pkg::SIZE_W;

    fbpa_pkg::t_state r_state, n_state;

    logic [SIZE_W-1:0]          r_chunk_size, n_chunk_size;
    logic [CNT_W-1:0]           r_chunk_count, n_chunk_count;
    logic [ADDR_W-1:0]          r_base, n_base;

    logic [CNT_W-1:0]           r_free_count, n_free_count;
    logic                       r_built, n_built;
    logic [fbpa_pkg::MAX_CHUNKS-1:0] r_used, n_used;

    logic [ADDR_W-1:0]          r_req, n_req;
    logic [ADDR_W-1:0]          r_faddr, n_faddr;
    logic [ADDR_W-1:0]          r_acc, n_acc;
    logic [IDX_W-1:0]           r_idx, n_idx;
    logic [IDX_W-1:0]           r_q, n_q;
    logic [IDX_W-1:0]           r_k, n_k;
    logic [BIT_W-1:0]           r_bit, n_bit;
    logic [ADDR_W-1:0]          r_res_addr, n_res_addr;
    logic                       r_res_ok, n_res_ok;
    logic                       r_out_valid, n_out_valid;
    logic [ADDR_W-1:0]          r_out_addr, n_out_addr;
    logic                       r_out_ok, n_out_ok;

    fbpa_pkg::t_alu_req         w_alu_req;
    fbpa_pkg::t_stack_req       w_stk_req;
    logic [ADDR_W-1:0]          w_sum;
    logic                       w_carry;
    logic [IDX_W-1:0]           w_rdata;

    logic [CNT_W-1:0]           w_eff;
    logic [CNT_W-1:0]           w_bld;
    logic                       w_need_build;
    logic                       w_alloc_ok;
    logic                       w_build_last;
    logic                       w_free_ok;
    logic                       w_slot_free;
    logic                       w_accept;

    fbpa_alu u_alu (
        .i_req   (w_alu_req),
        .o_sum   (w_sum),
        .o_carry (w_carry)
    );

    fbpa_stack u_stack (
        .i_clk   (i_clk),
        .i_req   (w_stk_req),
        .o_rdata (w_rdata)
    );

    assign w_eff = (r_chunk_count > CNT_W'(fbpa_pkg::MAX_CHUNKS))
                 ? CNT_W'(fbpa_pkg::MAX_CHUNKS) : r_chunk_count;
    assign w_bld = w_eff - CNT_W'(1) - {1'b0, r_k};
    assign w_build_last = ({1'b0, r_k} == (w_eff - CNT_W'(1)));
    assign w_need_build = !r_built && (w_eff != '0) && (r_chunk_size != '0);
    assign w_alloc_ok   = (r_req <= ADDR_W'(r_chunk_size)) && (r_free_count != '0);
    assign w_free_ok    = (r_acc == '0) && ({1'b0, r_q} < w_eff) && r_used[r_q]
                        && (r_free_count < CNT_W'(fbpa_pkg::MAX_CHUNKS));
    assign w_slot_free  = !r_out_valid || i_out_ready;
    assign o_in_ready   = (r_state == fbpa_pkg::S_IDLE);
    assign w_accept     = i_in_valid && o_in_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            fbpa_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (fbpa_pkg::t_op'(i_op) == fbpa_pkg::OP_FREE)
                            ? fbpa_pkg::S_FOFF : fbpa_pkg::S_ACHK;
                end
            end
            fbpa_pkg::S_ACHK: begin
                if (w_need_build) begin
                    n_state = fbpa_pkg::S_BUILD;
                end else if (w_alloc_ok) begin
                    n_state = fbpa_pkg::S_ARD;
                end else begin
                    n_state = fbpa_pkg::S_OUT;
                end
            end
            fbpa_pkg::S_BUILD: begin
                if (w_build_last) begin
                    n_state = fbpa_pkg::S_ACHK;
                end
            end
            fbpa_pkg::S_ARD:   n_state = fbpa_pkg::S_MUL;
            fbpa_pkg::S_MUL: begin
                if (r_bit == BIT_W'(IDX_W - 1)) begin
                    n_state = fbpa_pkg::S_ABASE;
                end
            end
            fbpa_pkg::S_ABASE: n_state = fbpa_pkg::S_OUT;
            fbpa_pkg::S_FOFF:  n_state = fbpa_pkg::S_FRNG;
            fbpa_pkg::S_FRNG: begin
                n_state = w_carry ? fbpa_pkg::S_OUT : fbpa_pkg::S_FDIV;
            end
            fbpa_pkg::S_FDIV: begin
                if (r_bit == '0) begin
                    n_state = fbpa_pkg::S_FCHK;
                end
            end
            fbpa_pkg::S_FCHK:  n_state = fbpa_pkg::S_OUT;
            fbpa_pkg::S_OUT: begin
                if (w_slot_free) begin
                    n_state = fbpa_pkg::S_IDLE;
                end
            end
            default:           n_state = fbpa_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_chunk_size  = r_chunk_size;
        n_chunk_count = r_chunk_count;
        n_base        = r_base;
        n_free_count  = r_free_count;
        n_built       = r_built;
        n_used        = r_used;
        n_req         = r_req;
        n_faddr       = r_faddr;
        n_acc         = r_acc;
        n_idx         = r_idx;
        n_q           = r_q;
        n_k           = r_k;
        n_bit         = r_bit;
        n_res_addr    = r_res_addr;
        n_res_ok      = r_res_ok;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_out_addr    = r_out_addr;
        n_out_ok      = r_out_ok;

        w_alu_req.sub = 1'b0;
        w_alu_req.a   = r_acc;
        w_alu_req.b   = ADDR_W'(r_chunk_size) << r_bit;

        w_stk_req.we    = 1'b0;
        w_stk_req.waddr = r_k;
        w_stk_req.wdata = w_bld[IDX_W-1:0];
        w_stk_req.raddr = r_free_count[IDX_W-1:0] - IDX_W'(1);

        if (i_cfg_we) begin
            case (fbpa_pkg::t_cfg_idx'(i_cfg_index))
                fbpa_pkg::CFG_CHUNK_SIZE:   n_chunk_size  = i_cfg_data[SIZE_W-1:0];
                fbpa_pkg::CFG_CHUNK_COUNT:  n_chunk_count = i_cfg_data[CNT_W-1:0];
                fbpa_pkg::CFG_BASE_ADDRESS: n_base        = i_cfg_data[ADDR_W-1:0];
                default: ;
            endcase
        end

        case (r_state)
            fbpa_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_req   = i_request_size;
                    n_faddr = i_free_address;
                end
            end
            fbpa_pkg::S_ACHK: begin
                if (w_need_build) begin
                    n_k = '0;
                end else if (w_alloc_ok) begin
                    n_free_count = r_free_count - CNT_W'(1);
                end else begin
                    n_res_addr = '0;
                    n_res_ok   = 1'b0;
                end
            end
            fbpa_pkg::S_BUILD: begin
                w_stk_req.we = 1'b1;
                n_k          = r_k + IDX_W'(1);
                if (w_build_last) begin
                    n_free_count = w_eff;
                    n_built      = 1'b1;
                end
            end
            fbpa_pkg::S_ARD: begin
                n_idx          = w_rdata;
                n_used[w_rdata] = 1'b1;
                n_acc          = '0;
                n_bit          = '0;
            end
            fbpa_pkg::S_MUL: begin
                if (r_idx[r_bit]) begin
                    n_acc = w_sum;
                end
                n_bit = r_bit + BIT_W'(1);
            end
            fbpa_pkg::S_ABASE: begin
                w_alu_req.b = r_base;
                n_res_addr  = w_sum;
                n_res_ok    = 1'b1;
            end
            fbpa_pkg::S_FOFF: begin
                w_alu_req.sub = 1'b1;
                w_alu_req.a   = r_faddr;
                w_alu_req.b   = r_base;
                n_acc         = w_sum;
            end
            fbpa_pkg::S_FRNG: begin
                // offset at or beyond size times max chunks can never map to an index
                w_alu_req.sub = 1'b1;
                w_alu_req.b   = ADDR_W'(r_chunk_size) << IDX_W;
                n_bit         = BIT_W'(IDX_W - 1);
                n_q           = '0;
                if (w_carry) begin
                    n_res_addr = '0;
                    n_res_ok   = 1'b0;
                end
            end
            fbpa_pkg::S_FDIV: begin
                w_alu_req.sub = 1'b1;
                if (w_carry) begin
                    n_acc      = w_sum;
                    n_q[r_bit] = 1'b1;
                end
                n_bit = r_bit - BIT_W'(1);
            end
            fbpa_pkg::S_FCHK: begin
                w_stk_req.waddr = r_free_count[IDX_W-1:0];
                w_stk_req.wdata = r_q;
                n_res_addr      = '0;
                n_res_ok        = w_free_ok;
                if (w_free_ok) begin
                    w_stk_req.we = 1'b1;
                    n_used[r_q]  = 1'b0;
                    n_free_count = r_free_count + CNT_W'(1);
                end
            end
            fbpa_pkg::S_OUT: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_addr  = r_res_addr;
                    n_out_ok    = r_res_ok;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= fbpa_pkg::S_IDLE;
            r_chunk_size  <= '0;
            r_chunk_count <= '0;
            r_base        <= '0;
            r_free_count  <= '0;
            r_built       <= 1'b0;
            r_used        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_chunk_size  <= n_chunk_size;
            r_chunk_count <= n_chunk_count;
            r_base        <= n_base;
            r_free_count  <= n_free_count;
            r_built       <= n_built;
            r_used        <= n_used;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_faddr    <= n_faddr;
        r_acc      <= n_acc;
        r_idx      <= n_idx;
        r_q        <= n_q;
        r_k        <= n_k;
        r_bit      <= n_bit;
        r_res_addr <= n_res_addr;
        r_res_ok   <= n_res_ok;
        r_out_addr <= n_out_addr;
        r_out_ok   <= n_out_ok;
    end

    assign o_out_valid = r_out_valid;
    assign o_address   = r_out_addr;
    assign o_in_pool   = r_out_ok;

`include "assert_macros.svh"

    `ASSERT_IMP(a_count_before_build, i_clk, i_rst_n, !r_built, r_free_count == '0)
    `ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_free_count <= CNT_W'(fbpa_pkg::MAX_CHUNKS))
    `ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, w_accept, !o_in_ready)
    `ASSERT_IMP(a_build_in_range, i_clk, i_rst_n, r_state == fbpa_pkg::S_BUILD, ({1'b0, r_k} < w_eff))

endmodule

>>> sim/fbpa_response_checker.sv
// response checker for the fixed block pool allocator: tracks config writes and accepted
// items, predicts pool answers and compares them with accepted results
// depends on fbpa_pkg
module fbpa_response_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [fbpa_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic                           i_op,
    input  logic [31:0]                    i_request_size,
    input  logic [31:0]                    i_free_address,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [31:0]                    i_address,
    input  logic                           i_in_pool,
    output int                             o_fail_count,
    output int                             o_pending
);

    localparam int MAX_CHUNKS = fbpa_pkg::MAX_CHUNKS;
    localparam int IDX_W      = fbpa_pkg::IDX_W;
    localparam int CNT_W      = fbpa_pkg::CNT_W;
    localparam int ADDR_W     = fbpa_pkg::ADDR_W;
    localparam int SIZE_W     = fbpa_pkg::SIZE_W;
    localparam int FIFO_DEPTH = 8;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic              in_pool;
    } t_pool_answer;

    t_pool_answer      answer_fifo [FIFO_DEPTH];
    int                fifo_wr;
    int                fifo_rd;
    t_pool_answer      want;
    t_pool_answer      got;

    logic [SIZE_W-1:0] chunk_size;
    logic [CNT_W-1:0]  chunk_count;
    logic [ADDR_W-1:0] base_address;
    logic [IDX_W-1:0]  free_stack [MAX_CHUNKS];
    logic [CNT_W-1:0]  free_count;
    logic              used_marks [MAX_CHUNKS];
    logic              pool_built;

    task automatic serve_pool_request(input fbpa_pkg::t_op op, input logic [31:0] req,
                                      input logic [31:0] faddr, output t_pool_answer ans);
        logic [CNT_W-1:0]  usable;
        logic [ADDR_W-1:0] offset;
        logic [ADDR_W-1:0] slot;
        logic [IDX_W-1:0]  idx;
        ans = '0;
        usable = (chunk_count > MAX_CHUNKS) ? CNT_W'(MAX_CHUNKS) : chunk_count;
        if (op == fbpa_pkg::OP_ALLOC) begin
            if (!pool_built && usable != 0 && chunk_size != 0) begin
                for (int k = 0; k < usable; k++)
                    free_stack[k] = IDX_W'(usable - 1 - k);
                free_count = usable;
                pool_built = 1'b1;
            end
            if (req <= chunk_size && free_count != 0) begin
                idx = free_stack[free_count - 1];
                free_count = free_count - 1;
                used_marks[idx] = 1'b1;
                ans.address = base_address + ADDR_W'(idx) * ADDR_W'(chunk_size);
                ans.in_pool = 1'b1;
            end
        end else if (chunk_size != 0) begin
            offset = faddr - base_address;
            slot = offset / ADDR_W'(chunk_size);
            if (offset % ADDR_W'(chunk_size) == 0 && slot < usable
                    && used_marks[slot[IDX_W-1:0]] && free_count < MAX_CHUNKS) begin
                used_marks[slot[IDX_W-1:0]] = 1'b0;
                free_stack[free_count[IDX_W-1:0]] = slot[IDX_W-1:0];
                free_count = free_count + 1;
                ans.in_pool = 1'b1;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            chunk_size = '0;
            chunk_count = '0;
            base_address = '0;
            free_count = '0;
            pool_built = 1'b0;
            for (int k = 0; k < MAX_CHUNKS; k++)
                used_marks[k] = 1'b0;
            fifo_wr = 0;
            fifo_rd = 0;
            o_fail_count = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (fifo_wr == fifo_rd) begin
                    $error("result with no item pending: address %h in_pool %b",
                           i_address, i_in_pool);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = answer_fifo[fifo_rd % FIFO_DEPTH];
                    fifo_rd = fifo_rd + 1;
                    got.address = i_address;
                    got.in_pool = i_in_pool;
                    if (got.address !== want.address) begin
                        $error("address mismatch: expected %h, actual %h",
                               want.address, got.address);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (got.in_pool !== want.in_pool) begin
                        $error("in_pool mismatch: expected %b, actual %b",
                               want.in_pool, got.in_pool);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    fbpa_pkg::CFG_CHUNK_SIZE:   chunk_size = i_cfg_data[SIZE_W-1:0];
                    fbpa_pkg::CFG_CHUNK_COUNT:  chunk_count = i_cfg_data[CNT_W-1:0];
                    fbpa_pkg::CFG_BASE_ADDRESS: base_address = i_cfg_data[ADDR_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                serve_pool_request(fbpa_pkg::t_op'(i_op), i_request_size, i_free_address,
                                   want);
                if (fifo_wr - fifo_rd >= FIFO_DEPTH) begin
                    $error("too many items pending: %0d", fifo_wr - fifo_rd);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    answer_fifo[fifo_wr % FIFO_DEPTH] = want;
                    fifo_wr = fifo_wr + 1;
                end
            end
        end
        o_pending = fifo_wr - fifo_rd;
    end

endmodule

>>> sim/fixed_block_pool_allocator_tb.sv
// testbench top for the fixed block pool allocator: directed and random allocate/free items
// under several pool settings and idle patterns, checked by fbpa_response_checker
// depends on fbpa_pkg, fbpa_response_checker and the allocator rtl
module fixed_block_pool_allocator_tb;

    localparam int STALL_LIMIT = 2000;
    localparam int ITEMS_PER_PHASE = 146;
    localparam int MAX_CHUNKS = fbpa_pkg::MAX_CHUNKS;
    localparam int CFG_IDX_W = fbpa_pkg::CFG_IDX_W;
    localparam int CFG_W = fbpa_pkg::CFG_W;
    localparam int SIZE_W = fbpa_pkg::SIZE_W;
    localparam int CNT_W = fbpa_pkg::CNT_W;
    localparam int ADDR_W = fbpa_pkg::ADDR_W;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic                 i_op = 1'b0;
    logic [31:0]          i_request_size = '0;
    logic [31:0]          i_free_address = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [31:0]          o_address;
    logic                 o_in_pool;

    int                   fail_count;
    int                   pending;
    int                   send_idle_pct = 36;
    int                   recv_idle_pct = 50;
    int                   chunks_in_use = 0;
    int                   stall_cycles = 0;
    logic [SIZE_W-1:0]    cur_size = '0;
    logic [CNT_W-1:0]     cur_count = '0;
    logic [ADDR_W-1:0]    cur_base = '0;

    always #5 i_clk = ~i_clk;

    fixed_block_pool_allocator DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_request_size (i_request_size),
        .i_free_address (i_free_address),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_address      (o_address),
        .o_in_pool      (o_in_pool)
    );

    fbpa_response_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_request_size (i_request_size),
        .i_free_address (i_free_address),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_address      (o_address),
        .i_in_pool      (o_in_pool),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("fixed_block_pool_allocator_tb: FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic set_pool(input logic [SIZE_W-1:0] size, input logic [CNT_W-1:0] count,
                            input logic [ADDR_W-1:0] base);
        i_cfg_we <= 1'b1;
        i_cfg_index <= fbpa_pkg::CFG_CHUNK_SIZE;
        i_cfg_data <= CFG_W'(size);
        @(negedge i_clk);
        i_cfg_index <= fbpa_pkg::CFG_CHUNK_COUNT;
        i_cfg_data <= CFG_W'(count);
        @(negedge i_clk);
        i_cfg_index <= fbpa_pkg::CFG_BASE_ADDRESS;
        i_cfg_data <= CFG_W'(base);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cur_size = size;
        cur_count = count;
        cur_base = base;
    endtask

    task automatic send_item(input fbpa_pkg::t_op op, input logic [31:0] req,
                             input logic [31:0] faddr);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= op;
        i_request_size <= req;
        i_free_address <= faddr;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        if (op == fbpa_pkg::OP_ALLOC)
            chunks_in_use = (chunks_in_use < MAX_CHUNKS) ? chunks_in_use + 1 : MAX_CHUNKS;
        else
            chunks_in_use = (chunks_in_use > 0) ? chunks_in_use - 1 : 0;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
    endtask

    task automatic random_item(input int alloc_pct);
        logic [31:0]   req;
        logic [31:0]   faddr;
        int            pick;
        int            k;
        fbpa_pkg::t_op op;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            req = $urandom_range(0, cur_size);
        else if (pick < 85)
            req = cur_size + $urandom_range(1, 16);
        else if (pick < 95)
            req = $urandom;
        else
            req = pick[0] ? 32'h0 : 32'hFFFF_FFFF;
        k = $urandom_range(0, chunks_in_use + 1);
        pick = $urandom_range(0, 99);
        if (pick < 70)
            faddr = cur_base + k * cur_size;
        else if (pick < 85)
            faddr = cur_base + k * cur_size + $urandom_range(1, 15);
        else
            faddr = $urandom;
        op = ($urandom_range(0, 99) < alloc_pct) ? fbpa_pkg::OP_ALLOC : fbpa_pkg::OP_FREE;
        send_item(op, req, faddr);
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // disabled pool: zero size, then zero count
        set_pool(17'd0, 9'd0, 32'h0);
        send_item(fbpa_pkg::OP_ALLOC, 32'd0, $urandom);
        send_item(fbpa_pkg::OP_FREE, $urandom, 32'h0);
        wait_drained();
        set_pool(17'd16, 9'd0, 32'h0000_1000);
        send_item(fbpa_pkg::OP_ALLOC, 32'd16, $urandom);
        send_item(fbpa_pkg::OP_FREE, $urandom, 32'h0000_1000);
        wait_drained();

        // build near the top of the address space, so chunk addresses wrap
        set_pool(17'd16, 9'd256, 32'hFFFF_FF00);
        send_item(fbpa_pkg::OP_ALLOC, 32'd0, $urandom);
        send_item(fbpa_pkg::OP_ALLOC, 32'd16, $urandom);
        send_item(fbpa_pkg::OP_ALLOC, 32'd17, $urandom);
        send_item(fbpa_pkg::OP_ALLOC, 32'hFFFF_FFFF, $urandom);
        send_item(fbpa_pkg::OP_FREE, $urandom, 32'hFFFF_FF00);
        send_item(fbpa_pkg::OP_FREE, $urandom, 32'hFFFF_FF00);
        send_item(fbpa_pkg::OP_FREE, $urandom, 32'hFFFF_FF11);
        send_item(fbpa_pkg::OP_FREE, $urandom, 32'h0000_0F00);
        send_item(fbpa_pkg::OP_FREE, $urandom, 32'hFFFF_FEF0);
        send_item(fbpa_pkg::OP_FREE, $urandom, 32'hFFFF_FF10);
        send_item(fbpa_pkg::OP_ALLOC, 32'd5, $urandom);
        send_item(fbpa_pkg::OP_ALLOC, 32'd5, $urandom);
        send_item(fbpa_pkg::OP_ALLOC, 32'd5, $urandom);
        wait_drained();

        // registers changed after the build
        set_pool(17'd65536, 9'd1, 32'hFFFF_FFFF);
        send_item(fbpa_pkg::OP_ALLOC, 32'd65536, $urandom);
        send_item(fbpa_pkg::OP_ALLOC, 32'd65537, $urandom);
        send_item(fbpa_pkg::OP_FREE, $urandom, 32'hFFFF_FFFF);
        send_item(fbpa_pkg::OP_FREE, $urandom, 32'h0000_FFFF);
        wait_drained();
        set_pool(17'd1, 9'd256, 32'h0);
        send_item(fbpa_pkg::OP_ALLOC, 32'd1, $urandom);
        send_item(fbpa_pkg::OP_ALLOC, 32'd2, $urandom);
        send_item(fbpa_pkg::OP_FREE, $urandom, 32'd2);
        send_item(fbpa_pkg::OP_FREE, $urandom, 32'd0);
        wait_drained();

        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 36 : (mode == 1) ? 50 : 0;
            recv_idle_pct = (mode == 0) ? 50 : (mode == 1) ? 36 : 0;
            for (int q = 0; q < 4; q++) begin
                case (q)
                    0: set_pool(SIZE_W'($urandom_range(1, 64)), 9'd256, $urandom);
                    1: set_pool(17'd65536, CNT_W'($urandom_range(1, 256)), 32'hFFFF_FFFF);
                    2: set_pool(17'd1, 9'd256, 32'h0);
                    default: begin
                        if (mode == 0)
                            set_pool(17'd0, 9'd256, $urandom);
                        else if (mode == 1)
                            set_pool(SIZE_W'($urandom_range(1, 65536)), 9'd0, $urandom);
                        else
                            set_pool(SIZE_W'($urandom_range(1, 65536)),
                                     CNT_W'($urandom_range(1, 256)), $urandom);
                    end
                endcase
                repeat (ITEMS_PER_PHASE)
                    random_item((q == 3) ? 30 : (q == 1) ? 90 : 85);
                wait_drained();
            end
        end

        repeat (20) @(negedge i_clk);
        if (fail_count == 0)
            $display("fixed_block_pool_allocator_tb: PASS");
        else
            $display("fixed_block_pool_allocator_tb: FAIL");
        $finish;
    end

endmodule
